### hw/rtl/scsw_pkg.sv
`default_nettype none

package scsw_pkg;

  // Heights and velocities are signed Q3.13
  localparam int DATA_W = 16;
  localparam int TARGET_W = 14;
  localparam int GAIN_W = 16;
  localparam int COUNT_W = 7;
  localparam int OUT_INDEX_W = 6;

  // Store depth and frame length defaults
  localparam int POINTS_DEFAULT = 64;

  // Animation speed 0.05 as unsigned Q0.16, kept with a zero sign bit
  localparam logic signed [13:0] SPEED_Q16 = 14'sd3277;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_TENSION     = 2'd1,
    REG_DAMPING     = 2'd2,
    REG_SPREAD      = 2'd3
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 7'd64;
  localparam logic [GAIN_W-1:0]  TENSION_RST     = 16'd6554;
  localparam logic [GAIN_W-1:0]  DAMPING_RST     = 16'd58982;
  localparam logic [GAIN_W-1:0]  SPREAD_RST      = 16'd6554;

  // Per-item sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_WB,
    ST_SPREAD
  } seq_state_t;

  // Clamp a 20-bit signed sum to the 16-bit signed range
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [19:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/scsw_ram.sv
`default_nettype none

module scsw_ram #(
  parameter int DEPTH = scsw_pkg::POINTS_DEFAULT,
  parameter int WIDTH = scsw_pkg::DATA_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/spring_chain_wave_step_unit.sv
`default_nettype none

// Damped spring chain, one point per transaction. Each accepted target is
// read against its stored height and velocity, pulled, moved and damped, and
// the new height leaves on the output stream with its index and a tlast on
// the final point of the frame. An item passes through accept and read,
// tension multiply, speed and damping multiply, and write-back, in that
// order, and a new item is taken only once the last one is past write-back:
// the next target is accepted in the cycle that writes the spread velocity
// of the previous interior point, so the item rate is set by the single
// write port of the velocity store, which takes up to two writes per item
// behind two dependent multiplies. The output register lets the input side
// keep going while one result waits; a second result stalls the write-back.
// After reset the block clears both stores to zero and accepts no target
// during that time; configuration writes are taken throughout.
module spring_chain_wave_step_unit #(
  parameter int POINTS = scsw_pkg::POINTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [scsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [15:0]                      s_axis_tdata,  // [13:0] target
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [23:0]                           m_axis_tdata,  // [15:0] new_point,
                                                               // [21:16] point_index
  output logic                                  m_axis_tlast   // frame_last
);

  import scsw_pkg::*;

  localparam int IDX_W = $clog2(POINTS);
  localparam int CW = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
  localparam logic [CW-1:0] POINTS_C = CW'(POINTS);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(POINTS - 1);

  // Configuration registers
  logic [COUNT_W-1:0] point_count;
  logic [GAIN_W-1:0]  tension;
  logic [GAIN_W-1:0]  damping;
  logic [GAIN_W-1:0]  spread;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RST;
      tension     <= TENSION_RST;
      damping     <= DAMPING_RST;
      spread      <= SPREAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POINT_COUNT: point_count <= cfg_data[COUNT_W-1:0];
        REG_TENSION:     tension     <= cfg_data[GAIN_W-1:0];
        REG_DAMPING:     damping     <= cfg_data[GAIN_W-1:0];
        REG_SPREAD:      spread      <= cfg_data[GAIN_W-1:0];
        default:         ;
      endcase
    end
  end

  // Sequencer state and control
  seq_state_t state, state_next;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] pos_cnt;
  logic             acc;
  logic             out_free;
  logic             out_load;
  logic             pt_we, vel_we;
  logic [IDX_W-1:0] pt_waddr, vel_waddr;
  logic [DATA_W-1:0] pt_wdata, vel_wdata;

  // Item registers
  logic [TARGET_W-1:0]      t_reg;
  logic [IDX_W-1:0]         i_reg;
  logic                     last_reg;
  logic signed [DATA_W-1:0] p_reg, v1_reg, p1_reg, v2_reg, vs_reg;

  // Chain registers
  logic signed [DATA_W-1:0] prev_pt, prev2_pt, pend_vel;

  // Store read data
  logic [DATA_W-1:0] pt_rdata, vel_rdata;

  // Frame position of the incoming item
  logic [CW-1:0]    cnt_eff;
  logic [IDX_W-1:0] in_idx;
  logic             in_last;
  logic             interior;

  always_comb begin
    if (point_count == '0) begin
      cnt_eff = CW'(1);
    end else if (CW'(point_count) > POINTS_C) begin
      cnt_eff = POINTS_C;
    end else begin
      cnt_eff = CW'(point_count);
    end
    in_idx  = (CW'(pos_cnt) >= cnt_eff) ? '0 : pos_cnt;
    in_last = (CW'(in_idx) + CW'(1)) >= cnt_eff;
  end

  assign interior = i_reg > IDX_W'(1);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign acc      = s_axis_tvalid && s_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  state_next = (clr_addr == LAST_ADDR) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = acc ? ST_MUL1 : ST_IDLE;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_WB;
      ST_WB:     state_next = out_free ? ST_SPREAD : ST_WB;
      ST_SPREAD: state_next = acc ? ST_MUL1 : ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Store ports and handshake
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    pt_we         = 1'b0;
    pt_waddr      = i_reg;
    pt_wdata      = p1_reg;
    vel_we        = 1'b0;
    vel_waddr     = i_reg;
    vel_wdata     = v2_reg;
    unique case (state)
      ST_CLEAR: begin
        pt_we     = 1'b1;
        pt_waddr  = clr_addr;
        pt_wdata  = '0;
        vel_we    = 1'b1;
        vel_waddr = clr_addr;
        vel_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_WB: begin
        pt_we    = 1'b1;
        vel_we   = 1'b1;
        out_load = out_free;
      end
      ST_SPREAD: begin
        s_axis_tready = 1'b1;
        vel_we        = interior;
        vel_waddr     = i_reg - IDX_W'(1);
        vel_wdata     = vs_reg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pos_cnt  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (acc) begin
        pos_cnt <= in_last ? '0 : in_idx + IDX_W'(1);
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (acc) begin
      t_reg    <= s_axis_tdata[TARGET_W-1:0];
      i_reg    <= in_idx;
      last_reg <= in_last;
    end
  end

  // Pull toward the target
  logic signed [16:0] diff;
  logic signed [33:0] prod_t;

  assign diff   = $signed({3'b000, t_reg}) - $signed({pt_rdata[DATA_W-1], pt_rdata});
  assign prod_t = diff * $signed({1'b0, tension});

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      p_reg  <= $signed(pt_rdata);
      v1_reg <= sat16($signed({{4{vel_rdata[DATA_W-1]}}, vel_rdata})
                      + $signed({{2{prod_t[33]}}, prod_t[33:16]}));
    end
  end

  // Move the point and damp the velocity
  logic signed [29:0] prod_s;
  logic signed [32:0] prod_d;

  assign prod_s = v1_reg * SPEED_Q16;
  assign prod_d = v1_reg * $signed({1'b0, damping});

  always_ff @(posedge clk) begin
    if (state == ST_MUL2) begin
      p1_reg <= sat16($signed({{4{p_reg[DATA_W-1]}}, p_reg})
                      + $signed({{6{prod_s[29]}}, prod_s[29:16]}));
      v2_reg <= sat16($signed({{3{prod_d[32]}}, prod_d[32:16]}));
    end
  end

  // Spread for the previous point, from its two neighbors
  logic signed [17:0] nb_sum;
  logic signed [34:0] prod_n;

  assign nb_sum = $signed({{2{prev2_pt[DATA_W-1]}}, prev2_pt})
                - $signed({{2{prev_pt[DATA_W-1]}}, prev_pt})
                + $signed({{2{p1_reg[DATA_W-1]}}, p1_reg})
                - $signed({{2{prev_pt[DATA_W-1]}}, prev_pt});
  assign prod_n = nb_sum * $signed({1'b0, spread});

  always_ff @(posedge clk) begin
    if (state == ST_WB) begin
      vs_reg <= sat16($signed({{4{pend_vel[DATA_W-1]}}, pend_vel})
                      + $signed({prod_n[34], prod_n[34:16]}));
    end
  end

  // Shift the chain history once the item is done
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pt  <= '0;
      prev2_pt <= '0;
      pend_vel <= '0;
    end else if (state == ST_SPREAD) begin
      prev2_pt <= (i_reg == '0) ? '0 : prev_pt;
      prev_pt  <= p1_reg;
      pend_vel <= v2_reg;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {2'b00, OUT_INDEX_W'(i_reg), p1_reg};
      m_axis_tlast <= last_reg;
    end
  end

  // Height and velocity stores
  scsw_ram #(
    .DEPTH (POINTS),
    .WIDTH (DATA_W)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (in_idx),
    .rdata (pt_rdata)
  );

  scsw_ram #(
    .DEPTH (POINTS),
    .WIDTH (DATA_W)
  ) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (vel_waddr),
    .wdata (vel_wdata),
    .raddr (in_idx),
    .rdata (vel_rdata)
  );

  // An accepted item always enters the multiply sequence
  a_acc_to_mul: assert property (@(posedge clk) disable iff (rst)
    acc |=> state == ST_MUL1)
    else $error("accepted item did not start the multiply sequence");

  // A result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // The spread write never touches the first point of a frame
  a_spread_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPREAD && vel_we) |-> vel_waddr != '0)
    else $error("spread written to an endpoint");

  // No target is taken while the stores are being cleared
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // The frame position stays inside the store
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    acc |=> CW'(pos_cnt) < POINTS_C)
    else $error("position counter out of range");

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;

  import scsw_pkg::*;

  localparam int DEPTH = POINTS_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 14;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic signed [DATA_W-1:0] height;
    logic [OUT_INDEX_W-1:0]   index;
    logic                     tail;
  } point_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [13:0] target
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // [15:0] new_point, [21:16] point_index
  logic m_axis_tlast;              // frame_last

  spring_chain_wave_step_unit #(
    .POINTS(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  // Register mirror, reset values from the package
  logic [COUNT_W-1:0] frame_len_reg = POINT_COUNT_RST;
  logic [GAIN_W-1:0]  tension_reg   = TENSION_RST;
  logic [GAIN_W-1:0]  damping_reg   = DAMPING_RST;
  logic [GAIN_W-1:0]  spread_reg    = SPREAD_RST;

  // Chain state as the block should hold it
  logic signed [DATA_W-1:0] height_mem [DEPTH];
  logic signed [DATA_W-1:0] speed_mem [DEPTH];
  logic signed [DATA_W-1:0] prev_height = '0;
  logic signed [DATA_W-1:0] prev2_height = '0;
  logic signed [DATA_W-1:0] held_speed = '0;
  int unsigned next_index = 0;

  logic [TARGET_W-1:0] target_queue [$];
  point_result_t       expected_points [$];

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  bit burst_mode = 1'b0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned targets_taken = 0;
  int unsigned frames_done = 0;
  int unsigned phases_run = 0;

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      height_mem[k] = '0;
      speed_mem[k] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] clamp16(input longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[DATA_W-1:0];
  endfunction

  // Product with a Q0.16 gain, floored
  function automatic longint scale_q16(input longint a, input logic [GAIN_W-1:0] g);
    return (a * longint'(g)) >>> 16;
  endfunction

  // Pull, move and damp one point, then spread onto the previous interior point
  function automatic point_result_t advance_chain(input logic [TARGET_W-1:0] tgt);
    point_result_t r;
    int unsigned len;
    int unsigned idx;
    longint p, v, v1, p1, v2, pp, pp2, diff_sum;
    len = (frame_len_reg == 0) ? 1 :
          (frame_len_reg > DEPTH) ? DEPTH : int'(frame_len_reg);
    if (next_index >= len) next_index = 0;
    idx = next_index;
    p = longint'(height_mem[idx]);
    v = longint'(speed_mem[idx]);
    v1 = clamp16(v + scale_q16(longint'(tgt) - p, tension_reg));
    p1 = clamp16(p + scale_q16(v1, DATA_W'(SPEED_Q16)));
    v2 = clamp16(scale_q16(v1, damping_reg));
    height_mem[idx] = clamp16(p1);
    speed_mem[idx] = clamp16(v2);
    pp = longint'(prev_height);
    pp2 = longint'(prev2_height);
    if (idx >= 2) begin
      diff_sum = (pp2 - pp) + (p1 - pp);
      speed_mem[idx-1] = clamp16(longint'(held_speed) + scale_q16(diff_sum, spread_reg));
    end
    prev2_height = (idx == 0) ? '0 : prev_height;
    prev_height = clamp16(p1);
    held_speed = clamp16(v2);
    r.height = clamp16(p1);
    r.index = idx[OUT_INDEX_W-1:0];
    r.tail = (idx + 1 >= len);
    next_index = r.tail ? 0 : idx + 1;
    return r;
  endfunction

  // Check results first, then predict the newly accepted target
  always @(posedge clk) begin : monitor
    point_result_t want;
    in_fire = !rst && s_axis_tvalid && s_axis_tready;
    out_fire = !rst && m_axis_tvalid && m_axis_tready;
    if (out_fire) begin
      if (m_axis_tlast) frames_done++;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual point %0d index %0d last %0b",
                 $time, $signed(m_axis_tdata[15:0]), m_axis_tdata[21:16], m_axis_tlast);
      end else begin
        want = expected_points.pop_front();
        if (m_axis_tdata[15:0] !== want.height) begin
          errors++;
          $display("%0t: new_point expected %0d actual %0d", $time, want.height,
                   $signed(m_axis_tdata[15:0]));
        end
        if (m_axis_tdata[21:16] !== want.index) begin
          errors++;
          $display("%0t: point_index expected %0d actual %0d", $time, want.index,
                   m_axis_tdata[21:16]);
        end
        if (m_axis_tlast !== want.tail) begin
          errors++;
          $display("%0t: frame_last expected %0b actual %0b", $time, want.tail, m_axis_tlast);
        end
      end
    end
    if (in_fire) begin
      expected_points.push_back(advance_chain(s_axis_tdata[TARGET_W-1:0]));
      targets_taken++;
    end
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
  end

  // Present the next target once the gap drawn for it has passed
  always @(negedge clk) begin : target_driver
    logic nxt_valid;
    logic [15:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data = s_axis_tdata;
    if (in_fire) nxt_valid = 1'b0;
    if (!nxt_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (target_queue.size() > 0) begin
        nxt_data = {2'b00, target_queue.pop_front()};
        nxt_valid = 1'b1;
        send_gap = burst_mode ? 0 : $urandom_range(0, 12);
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata <= nxt_data;
  end

  // Stall the result side for a drawn number of cycles after each transaction
  always @(negedge clk) begin : result_stall
    if (out_fire) hold_left = burst_mode ? 0 : $urandom_range(0, 12);
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_POINT_COUNT: frame_len_reg = value[COUNT_W-1:0];
      REG_TENSION:     tension_reg = value;
      REG_DAMPING:     damping_reg = value;
      REG_SPREAD:      spread_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample at the rising edge, where the driver's outputs have settled
  task automatic wait_drained();
    while (target_queue.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
      @(posedge clk);
  endtask

  // Drain, let the last spread write land, then load a new setting
  task automatic reconfigure(input logic [COUNT_W-1:0] cnt, input logic [GAIN_W-1:0] ten,
                             input logic [GAIN_W-1:0] dmp, input logic [GAIN_W-1:0] spr,
                             input bit burst);
    wait_drained();
    repeat (8) @(negedge clk);
    write_reg(REG_POINT_COUNT, CFG_DATA_W'(cnt));
    write_reg(REG_TENSION, ten);
    write_reg(REG_DAMPING, dmp);
    write_reg(REG_SPREAD, spr);
    burst_mode = burst;
    phases_run++;
  endtask

  function automatic logic [TARGET_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 14'd8192;
      2: return 14'h3fff;
      3: return TARGET_W'($urandom_range(8193, 16383));
      4: return TARGET_W'($urandom_range(0, 16383));
      default: return TARGET_W'($urandom_range(0, 8192));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 16'hffff;
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, idle_cycles, expected_points.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [COUNT_W-1:0] cnt;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: first points of a full frame, target extremes
    target_queue.push_back(14'd0);
    target_queue.push_back(14'd8192);
    target_queue.push_back(14'h3fff);

    // Three-point frames at full gains; counter restarts since it sits past the end
    reconfigure(7'd3, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'd0);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'd0);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'd8192);
    target_queue.push_back(14'd0);
    target_queue.push_back(14'd1);

    // One-point frames
    reconfigure(7'd1, 16'd32768, 16'd32768, 16'hffff, 1'b0);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'd0);
    target_queue.push_back(14'd8191);

    // Two-point frames, no damping carry
    reconfigure(7'd2, 16'hffff, 16'd0, 16'hffff, 1'b0);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'h2aaa);
    target_queue.push_back(14'h1555);

    // Zero length runs as one point
    reconfigure(7'd0, 16'd20000, 16'd50000, 16'd30000, 1'b0);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'd1);

    // Oversized length clamps to the store depth
    reconfigure(7'd127, 16'd0, 16'hffff, 16'd0, 1'b1);
    target_queue.push_back(14'd100);
    target_queue.push_back(14'h3fff);
    target_queue.push_back(14'd8192);
    target_queue.push_back(14'd0);

    // Random phases: extremes first, then random settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: cnt = 7'd64;
        1: cnt = 7'd127;
        2: cnt = 7'd1;
        3: cnt = 7'd3;
        4: cnt = 7'd0;
        default: cnt = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 127)) :
                                                     COUNT_W'($urandom_range(1, 64));
      endcase
      if (ph == 0)
        reconfigure(cnt, 16'hffff, 16'hffff, 16'hffff, 1'b0);
      else if (ph == 1)
        reconfigure(cnt, 16'd0, 16'd0, 16'd0, 1'b0);
      else
        reconfigure(cnt, pick_gain(), pick_gain(), pick_gain(), (ph % 3) == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) target_queue.push_back(pick_target());
    end

    // Drain and watch for stray results
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d targets through %0d register settings, %0d frames completed.",
             targets_taken, phases_run, frames_done);
    $display("Frame lengths included zero, one, two, three, full and oversized values.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/scsw_pkg.sv
hw/rtl/scsw_ram.sv
hw/rtl/spring_chain_wave_step_unit.sv
verif/tb.sv
